>>> rtl/core/rv32_pkg.sv
package rv32_pkg;

    localparam logic [6:0] OP_LOAD   = 7'b00000_11;
    localparam logic [6:0] OP_STORE  = 7'b01000_11;
    localparam logic [6:0] OP_IMM    = 7'b00100_11;
    localparam logic [6:0] OP_REG    = 7'b01100_11;
    localparam logic [6:0] OP_LUI    = 7'b01101_11;
    localparam logic [6:0] OP_AUIPC  = 7'b00101_11;
    localparam logic [6:0] OP_BRANCH = 7'b11000_11;
    localparam logic [6:0] OP_JAL    = 7'b11011_11;
    localparam logic [6:0] OP_JALR   = 7'b11001_11;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // funct3 codes of the integer alu
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 codes of the m extension
    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    // funct3 codes of branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic [4:0]  rd_index;
        logic        rd_write;
        logic [31:0] rd_value;
        logic [31:0] next_pc;
        logic        mem_read;
        logic        mem_write;
        logic [1:0]  mem_size;
        logic        mem_signed;
        logic [31:0] mem_address;
        logic [31:0] mem_store_data;
        logic        unhandled;
    } t_res;

    typedef struct packed {
        t_res        res;
        logic        is_md;
        logic [2:0]  f3;
        logic [31:0] a;
        logic [31:0] b;
    } t_dec;

    typedef struct packed {
        t_dec        d;
        logic [63:0] prod;
        logic [31:0] rem;
        logic [31:0] dvd;
        logic [31:0] dvs;
        logic        neg_q;
        logic        neg_r;
        logic        bzero;
    } t_mdst;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                        input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        case (f3)
            F3_ADD:  r = alt ? a - b : a + b;
            F3_SLL:  r = a << b[4:0];
            F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: r = {31'd0, a < b};
            F3_XOR:  r = a ^ b;
            F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/rv32_ifs.sv
interface rv32_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
    modport source(output valid, instruction, pc, rs1_value, rs2_value, input ready);
    modport sink(input valid, instruction, pc, rs1_value, rs2_value, output ready);
endinterface

interface rv32_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic        mem_signed;
    logic [31:0] mem_address;
    logic [31:0] mem_store_data;
    logic        unhandled;
    modport source(output valid, rd_index, rd_write, rd_value, next_pc, mem_read,
                   mem_write, mem_size, mem_signed, mem_address, mem_store_data,
                   unhandled, input ready);
    modport sink(input valid, rd_index, rd_write, rd_value, next_pc, mem_read,
                 mem_write, mem_size, mem_signed, mem_address, mem_store_data,
                 unhandled, output ready);
endinterface

>>> rtl/core/rv32_decode.sv
module rv32_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_instruction,
    input  logic [31:0]     i_pc,
    input  logic [31:0]     i_rs1_value,
    input  logic [31:0]     i_rs2_value,
    output logic            o_valid,
    output rv32_pkg::t_dec  o_dec
);
    import rv32_pkg::*;

    logic [31:0] ins, a, b, immI, immS, immB, immJ, immU, pc4, val, npc;
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic        wr, mr, bad, take;
    t_dec        n_dec;
    logic        r_valid;
    t_dec        r_dec;

    assign ins  = i_instruction;
    assign a    = i_rs1_value;
    assign b    = i_rs2_value;
    assign opc  = ins[6:0];
    assign f3   = ins[14:12];
    assign f7   = ins[31:25];
    assign immI = {{20{ins[31]}}, ins[31:20]};
    assign immS = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign immB = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign immJ = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    assign immU = {ins[31:12], 12'd0};
    assign pc4  = i_pc + 32'd4;

    // decode and execute everything but multiply and divide
    always_comb begin
        n_dec = '0;
        wr = 1'b0; mr = 1'b0; bad = 1'b0; take = 1'b0;
        val = '0; npc = pc4;
        n_dec.f3 = f3;
        n_dec.a = a;
        n_dec.b = b;
        case (opc)
            OP_LOAD: begin
                if (f3 == 3'd3 || f3 >= 3'd6) begin
                    bad = 1'b1;
                end else begin
                    mr = 1'b1; wr = 1'b1;
                    n_dec.res.mem_read = 1'b1;
                    n_dec.res.mem_size = f3[1:0];
                    n_dec.res.mem_signed = ~f3[2];
                    n_dec.res.mem_address = a + immI;
                end
            end
            OP_STORE: begin
                if (f3 > 3'd2) begin
                    bad = 1'b1;
                end else begin
                    n_dec.res.mem_write = 1'b1;
                    n_dec.res.mem_size = f3[1:0];
                    n_dec.res.mem_address = a + immS;
                    n_dec.res.mem_store_data = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                                               (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
                end
            end
            OP_IMM: begin
                if ((f3 == F3_SLL && f7 != F7_BASE) ||
                    (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)) begin
                    bad = 1'b1;
                end else begin
                    wr = 1'b1;
                    val = alu(f3, f3 == F3_SR && f7 == F7_ALT, a, immI);
                end
            end
            OP_REG: begin
                if (f7 == F7_MULDIV) begin
                    wr = 1'b1;
                    n_dec.is_md = 1'b1;
                end else if ((f7 == F7_ALT && f3 != F3_ADD && f3 != F3_SR) ||
                             (f7 != F7_BASE && f7 != F7_ALT)) begin
                    bad = 1'b1;
                end else begin
                    wr = 1'b1;
                    val = alu(f3, f7 == F7_ALT, a, b);
                end
            end
            OP_LUI: begin
                wr = 1'b1; val = immU;
            end
            OP_AUIPC: begin
                wr = 1'b1; val = i_pc + immU;
            end
            OP_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = a == b;
                    F3_BNE:  take = a != b;
                    F3_BLT:  take = $signed(a) < $signed(b);
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = a < b;
                    F3_BGEU: take = a >= b;
                    default: bad = 1'b1;
                endcase
                if (take) begin
                    npc = i_pc + immB;
                end
            end
            OP_JAL: begin
                wr = 1'b1; val = pc4; npc = i_pc + immJ;
            end
            OP_JALR: begin
                if (f3 != 3'd0) begin
                    bad = 1'b1;
                end else begin
                    wr = 1'b1; val = pc4; npc = (a + immI) & ~32'd1;
                end
            end
            default: bad = 1'b1;
        endcase
        n_dec.res.rd_index  = ins[11:7];
        n_dec.res.rd_write  = wr && ins[11:7] != 5'd0;
        n_dec.res.rd_value  = (wr && ins[11:7] != 5'd0 && !mr) ? val : 32'd0;
        n_dec.res.next_pc   = npc;
        n_dec.res.unhandled = bad;
    end

    // decode stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

>>> rtl/core/rv32_mdpipe.sv
module rv32_mdpipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rv32_pkg::t_dec  i_dec,
    output logic            o_valid,
    output rv32_pkg::t_res  o_res
);
    import rv32_pkg::*;

    logic               r_valid [0:DIV_STEPS];
    t_mdst              r_st    [0:DIV_STEPS];
    t_mdst              n_st    [0:DIV_STEPS];
    logic               r_out_valid;
    t_res               r_out;
    t_res               n_out;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    logic               sgn_div;
    logic [32:0]        trial [1:DIV_STEPS];
    logic [32:0]        shifted [1:DIV_STEPS];
    t_mdst              last;
    logic [31:0]        md;

    always_comb begin
        // setup: product and divider operand magnitudes
        ma = {(i_dec.f3 == F3_MULH || i_dec.f3 == F3_MULHSU) & i_dec.a[31], i_dec.a};
        mb = {(i_dec.f3 == F3_MULH) & i_dec.b[31], i_dec.b};
        mp = ma * mb;
        sgn_div = i_dec.f3 == F3_DIV || i_dec.f3 == F3_REM;
        n_st[0].d     = i_dec;
        n_st[0].prod  = mp[63:0];
        n_st[0].rem   = '0;
        n_st[0].dvd   = (sgn_div && i_dec.a[31]) ? -i_dec.a : i_dec.a;
        n_st[0].dvs   = (sgn_div && i_dec.b[31]) ? -i_dec.b : i_dec.b;
        n_st[0].neg_q = sgn_div && (i_dec.a[31] ^ i_dec.b[31]);
        n_st[0].neg_r = sgn_div && i_dec.a[31];
        n_st[0].bzero = i_dec.b == 32'd0;

        // one restoring division step per stage
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_st[k] = r_st[k-1];
            shifted[k] = {r_st[k-1].rem, r_st[k-1].dvd[31]};
            trial[k] = shifted[k] - {1'b0, r_st[k-1].dvs};
            if (!trial[k][32]) begin
                n_st[k].rem = trial[k][31:0];
            end else begin
                n_st[k].rem = shifted[k][31:0];
            end
            n_st[k].dvd = {r_st[k-1].dvd[30:0], ~trial[k][32]};
        end
    end

    // result select and sign fixup
    always_comb begin
        last = r_st[DIV_STEPS];
        case (last.d.f3)
            F3_MUL:                    md = last.prod[31:0];
            F3_MULH, F3_MULHSU, F3_MULHU: md = last.prod[63:32];
            F3_DIV, F3_DIVU:
                md = last.bzero ? 32'hFFFF_FFFF : (last.neg_q ? -last.dvd : last.dvd);
            default:
                md = last.bzero ? last.d.a : (last.neg_r ? -last.rem : last.rem);
        endcase
        n_out = last.d.res;
        if (last.d.is_md) begin
            n_out.rd_value = last.d.res.rd_write ? md : 32'd0;
        end
    end

    // stage registers, all advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
            r_out_valid <= r_valid[DIV_STEPS];
        end
        if (i_en) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
endmodule

>>> rtl/core/rv32im_execute_unit.sv
// RV32IM execute unit: takes one instruction per cycle while not held, with
// its pc and source register values, and returns one result per instruction,
// in order. Every instruction, plain alu work too, runs through the same
// pipeline: one decode stage, one multiply/setup stage, 32 radix-2 divide
// stages and an output register. The throughput is one instruction per cycle
// when not held. The pipeline advances as a whole; it holds while the
// output register carries a result that the sink does not take.
module rv32im_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rv32_req_if.sink    i_req,
    rv32_rsp_if.source  o_rsp
);
    import rv32_pkg::*;

    logic en;
    logic dec_valid;
    t_dec dec;
    t_res res;

    // pipeline moves unless a finished result is blocked
    assign en = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = en;

    rv32_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_req.valid),
        .i_instruction (i_req.instruction),
        .i_pc          (i_req.pc),
        .i_rs1_value   (i_req.rs1_value),
        .i_rs2_value   (i_req.rs2_value),
        .o_valid       (dec_valid),
        .o_dec         (dec)
    );

    rv32_mdpipe u_mdpipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (o_rsp.valid),
        .o_res   (res)
    );

    // result fields
    assign o_rsp.rd_index       = res.rd_index;
    assign o_rsp.rd_write       = res.rd_write;
    assign o_rsp.rd_value       = res.rd_value;
    assign o_rsp.next_pc        = res.next_pc;
    assign o_rsp.mem_read       = res.mem_read;
    assign o_rsp.mem_write      = res.mem_write;
    assign o_rsp.mem_size       = res.mem_size;
    assign o_rsp.mem_signed     = res.mem_signed;
    assign o_rsp.mem_address    = res.mem_address;
    assign o_rsp.mem_store_data = res.mem_store_data;
    assign o_rsp.unhandled      = res.unhandled;
endmodule
